FILE: hw/rtl/htwsd_pkg.sv
// Shared types and constants for the Huffman tree-walk sample decoder.
// Used by every RTL file of the decoder and by its port checker.
`default_nettype none

package htwsd_pkg;

  // Sizing
  localparam int SAMPLE_BITS  = 8;
  localparam int MAX_CHANNELS = 4;
  localparam int TREE_NODES   = 256;
  localparam int WORD_BITS    = 32;

  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int NODE_W    = $clog2(TREE_NODES);
  localparam int ADDR_W    = CH_W + NODE_W;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int CHILD_W   = 16;
  localparam int ENTRY_W   = 2 * CHILD_W;
  localparam int ROOT_W    = 8;
  localparam int ROW_W     = 16;
  localparam int NCH_W     = 3;
  localparam int CH_FIELD_W = 2;

  // Input word layout (tdata), lowest bits first
  localparam int IN_TCH_LO   = 0;
  localparam int IN_NODE_LO  = IN_TCH_LO + 2;
  localparam int IN_LEFT_LO  = IN_NODE_LO + 8;
  localparam int IN_RIGHT_LO = IN_LEFT_LO + CHILD_W;
  localparam int IN_CODE_LO  = IN_RIGHT_LO + CHILD_W;
  localparam int IN_BITS     = IN_CODE_LO + 32;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output word layout (tdata): sample value then channel
  localparam int OUT_BITS   = SAMPLE_BITS + CH_FIELD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes
  localparam logic [2:0] REG_CHANNELS    = 3'd0;
  localparam logic [2:0] REG_ROW_SAMPLES = 3'd1;
  localparam logic [2:0] REG_ROOT_CH0    = 3'd2;
  localparam logic [2:0] REG_ROOT_CH1    = 3'd3;
  localparam logic [2:0] REG_ROOT_CH2    = 3'd4;
  localparam logic [2:0] REG_ROOT_CH3    = 3'd5;

  // Reset values
  localparam logic [NCH_W-1:0] CHANNELS_RST = 3'd1;
  localparam logic [ROW_W-1:0] ROW_RST      = 16'd640;

  // Input word kinds (tuser)
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DECODE = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic [NCH_W-1:0]                   channels;
    logic [ROW_W-1:0]                   row_samples;
    logic [MAX_CHANNELS-1:0][ROOT_W-1:0] root;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [CH_FIELD_W-1:0]  channel;
    logic                   row_end;
  } sample_t;

  // Walker to output stage
  typedef struct packed {
    logic push;
    logic flush;
  } out_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/htwsd_cfg_regs.sv
// Register block of the decoder: channel count, row length, tree roots.
// Depends on htwsd_pkg.
`default_nettype none

module htwsd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [htwsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [htwsd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [htwsd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready,
  output htwsd_pkg::cfg_t                  cfg
);
  import htwsd_pkg::*;

  logic [NCH_W-1:0]                    channels_r;
  logic [ROW_W-1:0]                    row_samples_r;
  logic [MAX_CHANNELS-1:0][ROOT_W-1:0] root_r;
  logic                                wr_en;
  logic [2:0]                          reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r    <= CHANNELS_RST;
      row_samples_r <= ROW_RST;
      root_r        <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHANNELS:    channels_r    <= cfg_pwdata[NCH_W-1:0];
        REG_ROW_SAMPLES: row_samples_r <= cfg_pwdata[ROW_W-1:0];
        REG_ROOT_CH0:    root_r[0]     <= cfg_pwdata[ROOT_W-1:0];
        REG_ROOT_CH1:    root_r[1]     <= cfg_pwdata[ROOT_W-1:0];
        REG_ROOT_CH2:    root_r[2]     <= cfg_pwdata[ROOT_W-1:0];
        REG_ROOT_CH3:    root_r[3]     <= cfg_pwdata[ROOT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_CHANNELS:    cfg_prdata = CFG_DW'(channels_r);
      REG_ROW_SAMPLES: cfg_prdata = CFG_DW'(row_samples_r);
      REG_ROOT_CH0:    cfg_prdata = CFG_DW'(root_r[0]);
      REG_ROOT_CH1:    cfg_prdata = CFG_DW'(root_r[1]);
      REG_ROOT_CH2:    cfg_prdata = CFG_DW'(root_r[2]);
      REG_ROOT_CH3:    cfg_prdata = CFG_DW'(root_r[3]);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.channels    = channels_r;
  assign cfg.row_samples = row_samples_r;
  assign cfg.root        = root_r;

endmodule

`default_nettype wire

FILE: hw/rtl/htwsd_walker.sv
// Tree store, code word shift register and bit-serial tree walk with
// per-channel prediction state. Depends on htwsd_pkg.
`default_nettype none

module htwsd_walker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [htwsd_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]                     in_tuser,
  input  wire htwsd_pkg::cfg_t                cfg,
  input  wire logic                           room,
  output htwsd_pkg::out_ctl_t                 ctl,
  output htwsd_pkg::sample_t                  smp
);
  import htwsd_pkg::*;

  walk_state_t state_r, state_nxt;

  logic [ENTRY_W-1:0]   tree_mem_r [MAX_CHANNELS*TREE_NODES];
  logic [ENTRY_W-1:0]   ent_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CNT_W-1:0]     bit_cnt_r;
  logic [NODE_W-1:0]    node_r;
  logic                 at_root_r;
  logic [SAMPLE_BITS-1:0] prev_r [MAX_CHANNELS];
  logic [ROW_W-1:0]     row_r;
  logic [CH_W-1:0]      ch_r;

  logic                 accept;
  logic [1:0]           func;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CHILD_W-1:0]   child;
  logic                 is_node;
  logic                 step;
  logic                 leaf;
  logic                 last_bit;
  logic [NCH_W-1:0]     act;
  logic [NCH_W-1:0]     ch_inc;
  logic [CH_W-1:0]      ch_next;
  logic [CH_W-1:0]      ch_after;
  logic [ROW_W-1:0]     row_inc;
  logic                 row_done;
  logic [SAMPLE_BITS-1:0] sum;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign func      = in_tuser;

  // tree loads
  assign wr_en   = accept && (func == FUNC_LOAD);
  assign wr_addr = {in_tdata[IN_TCH_LO +: CH_W], in_tdata[IN_NODE_LO +: NODE_W]};
  assign wr_data = {in_tdata[IN_RIGHT_LO +: CHILD_W], in_tdata[IN_LEFT_LO +: CHILD_W]};

  // one walk step per unstalled cycle from the registered entry
  assign child    = word_r[WORD_BITS-1] ? ent_r[ENTRY_W-1 -: CHILD_W] : ent_r[CHILD_W-1:0];
  assign is_node  = child[CHILD_W-1];
  assign step     = (state_r == ST_WALK) && room;
  assign leaf     = step && !is_node;
  assign last_bit = (bit_cnt_r == CNT_W'(WORD_BITS - 1));

  // channel rotation; zero count acts as one, large counts saturate
  always_comb begin
    if (cfg.channels == '0) begin
      act = NCH_W'(1);
    end else if (cfg.channels > NCH_W'(MAX_CHANNELS)) begin
      act = NCH_W'(MAX_CHANNELS);
    end else begin
      act = cfg.channels;
    end
  end

  assign ch_inc   = NCH_W'(ch_r) + NCH_W'(1);
  assign ch_next  = (ch_inc >= act) ? '0 : ch_inc[CH_W-1:0];
  assign row_inc  = row_r + ROW_W'(1);
  assign row_done = (row_inc == cfg.row_samples);
  assign ch_after = row_done ? '0 : ch_next;
  assign sum      = child[SAMPLE_BITS-1:0] + prev_r[ch_r];

  // read address: fresh fetch at word start, then follow the walk
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {ch_r, node_r};
    if (state_r == ST_FETCH) begin
      rd_en   = 1'b1;
      rd_addr = {ch_r, at_root_r ? cfg.root[ch_r][NODE_W-1:0] : node_r};
    end else if (step) begin
      rd_en   = 1'b1;
      rd_addr = is_node ? {ch_r, child[NODE_W-1:0]}
                        : {ch_after, cfg.root[ch_after][NODE_W-1:0]};
    end
  end

  // tree store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ent_r <= tree_mem_r[rd_addr];
    end
  end

  // code word shift register
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_DECODE)) begin
      word_r <= in_tdata[IN_CODE_LO +: WORD_BITS];
    end else if (step) begin
      word_r <= {word_r[WORD_BITS-2:0], 1'b0};
    end
  end

  // walk position, prediction and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      node_r    <= '0;
      at_root_r <= 1'b1;
      row_r     <= '0;
      ch_r      <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) prev_r[i] <= '0;
    end else if (accept && (func == FUNC_START)) begin
      node_r    <= '0;
      at_root_r <= 1'b1;
      row_r     <= '0;
      ch_r      <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) prev_r[i] <= '0;
    end else if (accept && (func == FUNC_DECODE)) begin
      bit_cnt_r <= '0;
    end else if (step) begin
      bit_cnt_r <= bit_cnt_r + CNT_W'(1);
      if (is_node) begin
        node_r    <= child[NODE_W-1:0];
        at_root_r <= 1'b0;
      end else begin
        node_r    <= '0;
        at_root_r <= 1'b1;
        ch_r      <= ch_after;
        if (row_done) begin
          row_r <= '0;
          for (int i = 0; i < MAX_CHANNELS; i++) prev_r[i] <= '0;
        end else begin
          row_r        <= row_inc;
          prev_r[ch_r] <= sum;
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.push  = 1'b0;
    ctl.flush = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (func == FUNC_DECODE)) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        ctl.push = leaf;
        if (step && last_bit) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        ctl.flush = 1'b1;
        if (room) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign smp.value   = sum;
  assign smp.channel = CH_FIELD_W'(ch_r);
  assign smp.row_end = row_done;

endmodule

`default_nettype wire

FILE: hw/rtl/htwsd_out_stage.sv
// Holding register and output register of the result channel; the holding
// register delays each sample until it is known whether it ends the word.
// Depends on htwsd_pkg.
`default_nettype none

module htwsd_out_stage (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire htwsd_pkg::out_ctl_t             ctl,
  input  wire htwsd_pkg::sample_t              smp,
  output logic                                 room,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [htwsd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                           out_tuser,
  output logic                                 out_tlast
);
  import htwsd_pkg::*;

  sample_t pend_r;
  logic    pend_v_r;
  sample_t out_r;
  logic    out_v_r;
  logic    out_last_r;
  logic    out_free;
  logic    move;

  assign out_free = !out_v_r || out_tready;
  assign room     = !pend_v_r || out_free;
  assign move     = pend_v_r && out_free && (ctl.push || ctl.flush);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (ctl.push) begin
        pend_v_r <= 1'b1;
      end else if (move) begin
        pend_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      pend_r <= smp;
    end
    if (move) begin
      out_r      <= pend_r;
      out_last_r <= ctl.flush;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'({out_r.channel, out_r.value});
  assign out_tuser  = out_r.row_end;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/huffman_tree_walk_sample_decoder_core.sv
// Top level of the Huffman tree-walk sample decoder.
// Depends on htwsd_pkg, htwsd_cfg_regs, htwsd_walker and htwsd_out_stage.
//
// Usage:
//  in_*   words: tuser = func (load tree node, decode word, start frame).
//         Load and start frame keep in_tready high; a decode word holds it
//         low; its 32 bits are walked MSB first, one per unstalled cycle.
//  out_*  words: one decoded sample each; tuser = row end, tlast marks the
//         final sample of a compressed word.
//  cfg_*  register port; write only while no word is in flight.
//  A decode word runs through accept, one tree-store fetch, 32 walk steps
//  and one flush; each walk step is one read of the tree store whose
//  address follows from the previous entry. Loads and start frame do not
//  stall the input.
//  A sample waits in the holding register until the next sample of
//  the same word is found or the word's flush cycle, and is shown on out_*
//  from the cycle after that.
//  Reset clears registers, walk, prediction and row state; the tree store
//  keeps its contents and must be loaded before use.
//  A stalled receiver pauses the walk once the holding register is full.
`default_nettype none

module huffman_tree_walk_sample_decoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: tree_channel, node_index, left_child, right_child, code_word
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [htwsd_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: sample_value, sample_channel
  output logic [htwsd_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: row_end
  output logic [0:0]                           out_tuser,
  output logic                                 out_tlast,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [htwsd_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [htwsd_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic      [htwsd_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);
  import htwsd_pkg::*;

  cfg_t     cfg;
  out_ctl_t ctl;
  sample_t  smp;
  logic     room;

  htwsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  htwsd_walker u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .room      (room),
    .ctl       (ctl),
    .smp       (smp)
  );

  htwsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .smp        (smp),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/htwsd_checker.sv
// Port-level checks for the decoder top level, attached by bind.
// Depends on htwsd_pkg and huffman_tree_walk_sample_decoder_core.
`default_nettype none

module htwsd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [1:0]                      in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [htwsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]                      out_tuser,
  input wire logic                            out_tlast
);
  import htwsd_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // a decode word occupies the walker
  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_DECODE) |=> !in_tready)
    else $error("input ready during a word walk");

  // non-decode words leave the input ready
  a_ctl_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != FUNC_DECODE) |=> in_tready)
    else $error("non-decode word stalled the input");

  // samples only come out of a word walk
  a_out_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result word issued while idle");

endmodule

bind huffman_tree_walk_sample_decoder_core htwsd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
